// ===== rtl/shs_pkg.sv =====
// ============================================================================
// shs_pkg: shared types and constants of the stepper homing sequencer
// Holds the item structs, event codes, register indexes and command text.
// ============================================================================
`default_nettype none

package shs_pkg;

    // Full steps per motor revolution, default for the top-level parameter.
    localparam int MOTOR_FULL_STEPS_DEF = 200;

    // Largest microstep shift honored; larger register values act as this.
    localparam int MICROSTEP_MAX = 8;

    localparam int MICROSTEP_W  = 4;
    localparam int DELAY_W      = 20;
    localparam int STEP_W       = 31;
    localparam int REV_W        = 24;
    localparam int EVENT_W      = 2;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 20;

    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
    localparam logic [REV_W-1:0]  REV_MAX  = {REV_W{1'b1}};

    localparam logic [MICROSTEP_W-1:0] MICROSTEP_RST = 4'd3;
    localparam logic [DELAY_W-1:0]     DELAY_RST     = 20'd2500;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MICROSTEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY     = 2'd1;

    // Start command text and its length.
    localparam int CMD_LEN   = 9;
    localparam int CMD_IDX_W = 4;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 2'd0,
        EV_STARTED = 2'd1,
        EV_LIMIT   = 2'd2,
        EV_HOME    = 2'd3
    } event_t;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       limit_active;
    } tick_item_t;

    typedef struct packed {
        logic               step_pulse;
        logic               direction_cw;
        logic               driver_enable;
        logic [EVENT_W-1:0] event_code;
        logic [STEP_W-1:0]  steps_from_home;
        logic [REV_W-1:0]   revolutions;
        logic [DELAY_W-1:0] pulse_delay;
    } result_item_t;

    // Character of the text INITMOTOR at a given position.
    function automatic logic [7:0] start_char(input logic [CMD_IDX_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h49; // I
            4'd1:    ch = 8'h4E; // N
            4'd2:    ch = 8'h49; // I
            4'd3:    ch = 8'h54; // T
            4'd4:    ch = 8'h4D; // M
            4'd5:    ch = 8'h4F; // O
            4'd6:    ch = 8'h54; // T
            4'd7:    ch = 8'h4F; // O
            4'd8:    ch = 8'h52; // R
            default: ch = 8'h49;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stepper_homing_sequencer.sv =====
// ============================================================================
// stepper_homing_sequencer: start command, outward run and homing of a stepper
// One tick item in, one result item out; counts steps and revolutions.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  --------------------------
//  tick      in         tick_valid / tick_ready    tick (tick_item_t)
//  result    out        result_valid / result_ready result (result_item_t)
//  config    in         cfg_we, write only         cfg_index, cfg_data
//
// Each tick item is held first in the input register and then in the
// result register. The sustained rate is one item per cycle while the
// result is taken; the step, revolution and match counters are updated
// in the single cycle an item leaves the input register.
// A stalled result holds the result register, which holds the input register,
// and only then drops tick_ready. Reset is asynchronous and active low; it
// clears all control state and loads the register defaults (microstep shift
// 3, step delay 2500, direction clockwise). No clearing pass is needed.
// ============================================================================
`default_nettype none

module stepper_homing_sequencer
    import shs_pkg::*;
#(
    parameter int MOTOR_FULL_STEPS = MOTOR_FULL_STEPS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   tick_valid,
    output logic                        tick_ready,
    input  wire tick_item_t             tick,

    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_item_t                result,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Width of the position-in-revolution counter: enough for the longest
    // revolution period, full steps shifted by the largest microstep shift.
    localparam int PERIOD_W = $clog2((MOTOR_FULL_STEPS << MICROSTEP_MAX) + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MICROSTEP_W-1:0] microstep_reg;
    logic [DELAY_W-1:0]     delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            microstep_reg <= MICROSTEP_RST;
            delay_reg     <= DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MICROSTEP: microstep_reg <= cfg_data[MICROSTEP_W-1:0];
                REG_DELAY:     delay_reg     <= cfg_data[DELAY_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. The input
    // register empties whenever the result register can take an item.
    // ------------------------------------------------------------------
    logic         in_valid_reg;
    tick_item_t   in_item_reg;
    logic         advance;
    logic         fire;

    assign advance    = !result_valid || result_ready;
    assign fire       = in_valid_reg && advance;
    assign tick_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_valid && tick_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            in_item_reg <= tick;
        end
    end

    // ------------------------------------------------------------------
    // Start command matcher
    // ------------------------------------------------------------------
    logic started;

    shs_matcher u_matcher (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .rx_valid (in_item_reg.rx_valid),
        .rx_byte  (in_item_reg.rx_byte),
        .started  (started)
    );

    // ------------------------------------------------------------------
    // Motion state
    // ------------------------------------------------------------------
    logic                motor_active_reg,   motor_active_next;
    logic                returning_reg,      returning_next;
    logic                direction_reg,      direction_next;
    logic [STEP_W-1:0]   step_count_reg,     step_count_next;
    logic [PERIOD_W-1:0] step_in_rev_reg,    step_in_rev_next;
    logic [REV_W-1:0]    rev_count_reg,      rev_count_next;

    logic [MICROSTEP_W-1:0] shift;
    logic [PERIOD_W-1:0]    period;
    logic [PERIOD_W:0]      sir_inc;
    logic [PERIOD_W-1:0]    sir_back;
    logic                   pulse;
    event_t                 event_code;

    // Resolution values beyond the largest supported act as the largest.
    assign shift  = (microstep_reg > MICROSTEP_W'(MICROSTEP_MAX))
                    ? MICROSTEP_W'(MICROSTEP_MAX) : microstep_reg;
    assign period = PERIOD_W'(MOTOR_FULL_STEPS) << shift;

    assign sir_inc = (PERIOD_W + 1)'(step_in_rev_reg) + (PERIOD_W + 1)'(1);

    // Moving back, a position of zero or one left out of range by a
    // resolution change restarts at the top of the revolution.
    assign sir_back = (step_in_rev_reg == '0 || step_in_rev_reg > period)
                      ? period - PERIOD_W'(1)
                      : step_in_rev_reg - PERIOD_W'(1);

    always_comb
    begin
        motor_active_next = motor_active_reg;
        returning_next    = returning_reg;
        direction_next    = direction_reg;
        step_count_next   = step_count_reg;
        step_in_rev_next  = step_in_rev_reg;
        rev_count_next    = rev_count_reg;
        pulse             = 1'b0;
        event_code        = EV_NONE;

        if (started)
        begin
            // A completed command restarts the run even while moving.
            step_count_next   = '0;
            step_in_rev_next  = '0;
            rev_count_next    = '0;
            motor_active_next = 1'b1;
            returning_next    = 1'b0;
            direction_next    = 1'b1;
            event_code        = EV_STARTED;
        end
        else if (motor_active_reg && !returning_reg && in_item_reg.limit_active)
        begin
            // Limit switch reached: turn around, no step on this tick.
            returning_next = 1'b1;
            direction_next = 1'b0;
            event_code     = EV_LIMIT;
        end
        else if (motor_active_reg && !returning_reg)
        begin
            // Outward run. At the top of the step count the pulse still
            // goes out but no counter moves.
            pulse = 1'b1;
            if (step_count_reg != STEP_MAX)
            begin
                step_count_next = step_count_reg + STEP_W'(1);
                if (sir_inc >= (PERIOD_W + 1)'(period))
                begin
                    step_in_rev_next = '0;
                    if (rev_count_reg != REV_MAX)
                    begin
                        rev_count_next = rev_count_reg + REV_W'(1);
                    end
                end
                else
                begin
                    step_in_rev_next = sir_inc[PERIOD_W-1:0];
                end
            end
        end
        else if (motor_active_reg)
        begin
            // Return run down to zero, then stop and report home.
            if (step_count_reg != '0)
            begin
                pulse            = 1'b1;
                step_count_next  = step_count_reg - STEP_W'(1);
                step_in_rev_next = sir_back;
                if (sir_back == '0 && rev_count_reg != '0)
                begin
                    rev_count_next = rev_count_reg - REV_W'(1);
                end
            end
            else
            begin
                motor_active_next = 1'b0;
                returning_next    = 1'b0;
                event_code        = EV_HOME;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_active_reg <= 1'b0;
            returning_reg    <= 1'b0;
            direction_reg    <= 1'b1;
            step_count_reg   <= '0;
            step_in_rev_reg  <= '0;
            rev_count_reg    <= '0;
        end
        else if (fire)
        begin
            motor_active_reg <= motor_active_next;
            returning_reg    <= returning_next;
            direction_reg    <= direction_next;
            step_count_reg   <= step_count_next;
            step_in_rev_reg  <= step_in_rev_next;
            rev_count_reg    <= rev_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic         result_valid_reg;
    result_item_t result_reg;
    result_item_t result_next;

    always_comb
    begin
        result_next.step_pulse      = pulse;
        result_next.direction_cw    = direction_next;
        result_next.driver_enable   = motor_active_next;
        result_next.event_code      = event_code;
        result_next.steps_from_home = step_count_next;
        result_next.revolutions     = rev_count_next;
        result_next.pulse_delay     = pulse ? delay_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/shs_matcher.sv =====
// ============================================================================
// shs_matcher: start command matcher
// Checks one received byte per processed tick against the text INITMOTOR.
// ============================================================================
`default_nettype none

module shs_matcher
    import shs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       rx_valid,
    input  wire logic [7:0] rx_byte,
    output logic            started
);

    logic [CMD_IDX_W-1:0] match_index_reg;
    logic [CMD_IDX_W-1:0] match_index_next;
    logic [CMD_IDX_W-1:0] pos;
    logic [CMD_IDX_W-1:0] pos_inc;

    assign pos     = (match_index_reg < CMD_IDX_W'(CMD_LEN)) ? match_index_reg : '0;
    assign pos_inc = pos + CMD_IDX_W'(1);

    always_comb
    begin
        match_index_next = match_index_reg;
        started          = 1'b0;
        if (fire && rx_valid)
        begin
            if (rx_byte == start_char(pos))
            begin
                if (pos_inc >= CMD_IDX_W'(CMD_LEN))
                begin
                    // Whole command seen; start over for the next one.
                    match_index_next = '0;
                    started          = 1'b1;
                end
                else
                begin
                    match_index_next = pos_inc;
                end
            end
            else
            begin
                // A mismatching byte may itself open a new command.
                match_index_next = (rx_byte == start_char('0)) ? CMD_IDX_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_index_reg <= '0;
        end
        else
        begin
            match_index_reg <= match_index_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/shs_checker.sv =====
// ============================================================================
// shs_checker: port-level checks of the stepper homing sequencer
// Watches the result channel for consistent event reports and stable stalls.
// ============================================================================
`default_nettype none

module shs_checker
    import shs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         result_valid,
    input  wire logic         result_ready,
    input  wire result_item_t result
);

    // A stalled result item must hold still until taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    // The delay value only accompanies an actual step pulse.
    a_delay_with_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.step_pulse |-> result.pulse_delay == '0)
        else $error("pulse delay reported without a step pulse");

    // A start clears the counters and drives clockwise with the driver on.
    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_code == EV_STARTED |->
            result.driver_enable && result.direction_cw && !result.step_pulse &&
            result.steps_from_home == '0 && result.revolutions == '0)
        else $error("start event with inconsistent state");

    // Turning at the limit issues no step and reverses with the driver on.
    a_limit_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_code == EV_LIMIT |->
            result.driver_enable && !result.direction_cw && !result.step_pulse)
        else $error("limit event with inconsistent state");

    // Arrival at home means zero steps, driver off, no pulse.
    a_home_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_code == EV_HOME |->
            !result.driver_enable && !result.step_pulse &&
            result.steps_from_home == '0)
        else $error("home event with inconsistent state");

endmodule

bind stepper_homing_sequencer shs_checker u_shs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
